// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/mmdl_pkg.sv
package mmdl_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int TAP_COUNT  = 4;
    localparam int FRAC_BITS  = 8;

    localparam int SAMPLE_W = 16;
    localparam int SPAN_W   = 12;
    localparam int WGT_W    = 16;
    localparam int ADDR_W   = $clog2(RING_DEPTH);
    localparam int TAP_W    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int SPAN_MAX = RING_DEPTH - 3;

    localparam int V_W    = SAMPLE_W + FRAC_BITS + 2;
    localparam int PROD_W = V_W + WGT_W + 1;
    localparam int ACC_W  = PROD_W + TAP_W;

    // sequencer timing inside one item
    localparam int ACC_FIRST = 6;
    localparam int LAST_CNT  = 2 * TAP_COUNT + 4;
    localparam int CNT_W     = $clog2(LAST_CNT + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SPAN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAW_WINDOW = 1'd1;

    typedef struct packed {
        logic [ADDR_W-1:0]    li;
        logic [ADDR_W-1:0]    ri;
        logic [FRAC_BITS-1:0] frac;
        logic [WGT_W-1:0]     weight;
        logic                 lv;
        logic                 rv;
    } tap_addr_t;

    typedef struct packed {
        logic cap_left;
        logic acc_clr;
        logic acc_en;
    } mmdl_ctl_t;

    // raised cosine window points at |mod| = k/16
    function automatic logic [WGT_W-1:0] win_point(input logic [4:0] idx);
        logic [WGT_W-1:0] w;
        case (idx)
            5'd0:    w = 16'd32768;
            5'd1:    w = 16'd32453;
            5'd2:    w = 16'd31521;
            5'd3:    w = 16'd30007;
            5'd4:    w = 16'd27969;
            5'd5:    w = 16'd25486;
            5'd6:    w = 16'd22654;
            5'd7:    w = 16'd19580;
            5'd8:    w = 16'd16384;
            5'd9:    w = 16'd13188;
            5'd10:   w = 16'd10114;
            5'd11:   w = 16'd7282;
            5'd12:   w = 16'd4799;
            5'd13:   w = 16'd2761;
            5'd14:   w = 16'd1247;
            5'd15:   w = 16'd315;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

endpackage

// File: design/mmdl_ram.sv
module mmdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/mmdl_tap.sv
module mmdl_tap
    import mmdl_pkg::*;
(
    input  logic                       aclk,
    input  logic [ADDR_W-1:0]          span,
    input  logic [ADDR_W-1:0]          len,
    input  logic [ADDR_W-1:0]          wp,
    input  logic [ADDR_W-1:0]          fill,
    input  logic                       saw,
    input  logic signed [SAMPLE_W-1:0] mod,
    output tap_addr_t                  tap
);

    logic [16:0]             dm;
    logic [ADDR_W+16:0]      off_prod;
    logic [SAMPLE_W-1:0]     amag;
    logic [4:0]              widx;
    logic [10:0]             wfrac;
    logic [27:0]             wa_next;
    logic [27:0]             wb_next;

    logic [ADDR_W-1:0]       ipart_reg;
    logic [FRAC_BITS-1:0]    frac_reg;
    logic [27:0]             wa_reg;
    logic [27:0]             wb_reg;

    logic [ADDR_W:0]         ip;
    logic [ADDR_W:0]         li_ext;
    logic [ADDR_W:0]         ri_ext;
    logic [ADDR_W-1:0]       li;
    logic [ADDR_W-1:0]       ri;
    logic [28:0]             wsum;
    tap_addr_t               tap_next;

    // stage 1: offset product and window partial products
    always_comb begin
        dm       = 17'h08000 - {mod[SAMPLE_W-1], mod};
        off_prod = span * dm;
        amag     = mod[SAMPLE_W-1] ? (~mod + 16'd1) : mod;
        widx     = amag[15:11];
        wfrac    = amag[10:0];
        wa_next  = win_point(widx) * (12'd2048 - {1'b0, wfrac});
        wb_next  = win_point(widx + 5'd1) * wfrac;
    end

    always_ff @(posedge aclk) begin
        ipart_reg <= off_prod[16 +: ADDR_W];
        frac_reg  <= off_prod[16-FRAC_BITS +: FRAC_BITS];
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
    end

    // stage 2: ring addresses, weight, fill check
    always_comb begin
        ip     = {1'b0, ipart_reg} + {1'b0, wp} + (ADDR_W+1)'(1);
        li_ext = (ip >= {1'b0, len}) ? (ip - {1'b0, len}) : ip;
        li     = li_ext[ADDR_W-1:0];
        ri_ext = {1'b0, li} + (ADDR_W+1)'(1);
        ri     = (ri_ext == {1'b0, len}) ? '0 : ri_ext[ADDR_W-1:0];
        wsum   = {1'b0, wa_reg} + {1'b0, wb_reg};

        tap_next.li     = li;
        tap_next.ri     = ri;
        tap_next.frac   = frac_reg;
        tap_next.weight = saw ? wsum[11 +: WGT_W] : 16'd32768;
        tap_next.lv     = (li < fill);
        tap_next.rv     = (ri < fill);
    end

    always_ff @(posedge aclk) begin
        tap <= tap_next;
    end

endmodule

// File: design/mmdl_mac.sv
module mmdl_mac
    import mmdl_pkg::*;
(
    input  logic                       aclk,
    input  mmdl_ctl_t                  ctl,
    input  tap_addr_t                  tap,
    input  logic signed [SAMPLE_W-1:0] rdata,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    logic signed [SAMPLE_W-1:0]  left_reg;
    logic [FRAC_BITS-1:0]        frac3_reg;
    logic [WGT_W-1:0]            w3_reg;
    logic                        rv3_reg;
    logic [WGT_W-1:0]            w4_reg;
    logic signed [V_W-1:0]       v_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;

    logic signed [SAMPLE_W-1:0]  right;
    logic signed [SAMPLE_W:0]    diff;
    logic signed [V_W-1:0]       dprod;
    logic signed [V_W-1:0]       lext;
    logic signed [V_W-1:0]       v_next;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     rnd;
    logic signed [ACC_W-1:0]     shf;

    // interpolation between neighbours
    always_comb begin
        right  = rv3_reg ? rdata : '0;
        diff   = {right[SAMPLE_W-1], right} - {left_reg[SAMPLE_W-1], left_reg};
        dprod  = diff * $signed({1'b0, frac3_reg});
        lext   = V_W'(left_reg);
        v_next = (lext <<< FRAC_BITS) + dprod;
    end

    always_comb begin
        acc_next = ctl.acc_clr ? '0 : acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.cap_left) begin
            left_reg  <= tap.lv ? rdata : '0;
            frac3_reg <= tap.frac;
            w3_reg    <= tap.weight;
            rv3_reg   <= tap.rv;
        end
        w4_reg   <= w3_reg;
        v_reg    <= v_next;
        prod_reg <= v_reg * $signed({1'b0, w4_reg});
        if (ctl.acc_clr || ctl.acc_en) begin
            acc_reg <= acc_next;
        end
    end

    // round half up, then saturate
    always_comb begin
        rnd = acc_reg + (ACC_W'(1) <<< (FRAC_BITS + 14));
        shf = rnd >>> (FRAC_BITS + 15);
        if (shf > ACC_W'(32767)) begin
            sample_out = 16'sh7fff;
        end else if (shf < -ACC_W'(32768)) begin
            sample_out = 16'sh8000;
        end else begin
            sample_out = shf[SAMPLE_W-1:0];
        end
    end

endmodule

// File: design/multitap_modulated_delay_line_top.sv
// four-tap modulated delay line with linear interpolation
//
// s_ channel: one transfer carries the audio sample and the four tap
// modulation values; m_ channel: one transfer per input carrying the
// rounded, saturated sum of the taps. cfg_wr_en writes cfg_data into the
// register cfg_index picks (0 delay span, 1 saw window); the user keeps
// this to idle only, the block itself does not enforce it.
//
// an item is taken in the idle state, runs through the tap sequencer,
// then posts the result and stores the sample together once the output
// register is free; no new item is taken until that store. the history
// ring sits in one single-port ram and the sequencer reads that port
// twice per tap (left and right neighbour) and writes it once per item.
//
// reset clears the write position, the registers and the result valid;
// ring entries not yet written since reset read as zero through a
// high-water fill count, so no clearing pass is needed.
// a stalled receiver holds the result; the block still takes one new item
// and finishes it, then waits until the output register is free.
module multitap_modulated_delay_line_top
    import mmdl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample_in, mod_tap0, mod_tap1, mod_tap2, mod_tap3
    input  logic [79:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sample_out
    output logic [15:0]          m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SPAN_W-1:0]    cfg_data
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [SPAN_W-1:0]          delay_span_reg;
    logic                       saw_window_reg;
    logic [ADDR_W-1:0]          pos_reg;
    logic [ADDR_W-1:0]          fill_reg;
    logic [ADDR_W-1:0]          span_reg;
    logic [ADDR_W-1:0]          len_reg;
    logic [ADDR_W-1:0]          wp_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SAMPLE_W-1:0]        mod_reg [TAP_COUNT];
    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        m_tdata_reg;

    logic [ADDR_W-1:0]          span_next;
    logic [ADDR_W-1:0]          len_next;
    logic [ADDR_W-1:0]          wp_next;
    logic [ADDR_W:0]            wp_inc;
    logic                       s_xfer;
    logic                       out_free;

    logic [ADDR_W-1:0]          ram_addr;
    logic                       ram_we;
    logic [SAMPLE_W-1:0]        ram_rdata;
    tap_addr_t                  tap;
    mmdl_ctl_t                  ctl;
    logic signed [SAMPLE_W-1:0] mac_out;
    logic [TAP_W-1:0]           tap_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign tap_idx  = cnt_reg[TAP_W:1];

    always_comb begin
        if (32'(delay_span_reg) > SPAN_MAX) begin
            span_next = ADDR_W'(SPAN_MAX);
        end else begin
            span_next = ADDR_W'(delay_span_reg);
        end
        len_next = span_next + ADDR_W'(2);
        wp_next  = (pos_reg >= len_next) ? '0 : pos_reg;
        wp_inc   = {1'b0, wp_reg} + (ADDR_W+1)'(1);
    end

    always_comb begin
        ctl.cap_left = (state_reg == ST_RUN) && cnt_reg[0];
        ctl.acc_clr  = s_xfer;
        ctl.acc_en   = (state_reg == ST_RUN) && !cnt_reg[0]
                       && (32'(cnt_reg) >= ACC_FIRST) && (32'(cnt_reg) <= LAST_CNT);
        ram_we       = (state_reg == ST_DONE) && out_free;
        if (state_reg == ST_RUN) begin
            ram_addr = cnt_reg[0] ? tap.ri : tap.li;
        end else begin
            ram_addr = wp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_span_reg <= '0;
            saw_window_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DELAY_SPAN: delay_span_reg <= cfg_data;
                CFG_SAW_WINDOW: saw_window_reg <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            for (int t = 0; t < TAP_COUNT; t++) begin
                mod_reg[t] <= s_tdata[(t+1)*SAMPLE_W +: SAMPLE_W];
            end
            span_reg <= span_next;
            len_reg  <= len_next;
            wp_reg   <= wp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            pos_reg      <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ram_we) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= mac_out;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        state_reg <= ST_RUN;
                        cnt_reg   <= '0;
                    end
                end
                ST_RUN: begin
                    if (32'(cnt_reg) == LAST_CNT) begin
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        pos_reg      <= (wp_inc >= {1'b0, len_reg}) ? '0
                                                                    : wp_inc[ADDR_W-1:0];
                        if (wp_reg >= fill_reg) begin
                            fill_reg <= wp_inc[ADDR_W-1:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    mmdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    mmdl_tap u_tap (
        .aclk (aclk),
        .span (span_reg),
        .len  (len_reg),
        .wp   (wp_reg),
        .fill (fill_reg),
        .saw  (saw_window_reg),
        .mod  (mod_reg[tap_idx]),
        .tap  (tap)
    );

    mmdl_mac u_mac (
        .aclk       (aclk),
        .ctl        (ctl),
        .tap        (tap),
        .rdata      (ram_rdata),
        .sample_out (mac_out)
    );

    `ASSERT_SYNC(a_pos_in_fill, (pos_reg <= fill_reg), "write position past fill count")
    `ASSERT_SYNC(a_accept_starts, s_xfer |=> cnt_reg == '0 && state_reg == ST_RUN, "no start")
    `ASSERT_SYNC(a_store_posts, (ram_we |=> m_tvalid_reg), "sample stored without posting result")

endmodule

// File: bench/multitap_modulated_delay_line_top_test.sv
module multitap_modulated_delay_line_top_test
    import mmdl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 30;
    localparam int RANDOM_ITEMS = 1200;
    localparam int COS_PTS [18] = '{
        32768, 32453, 31521, 30007, 27969, 25486, 22654, 19580, 16384,
        13188, 10114, 7282, 4799, 2761, 1247, 315, 0, 0
    };

    typedef struct packed {
        logic [TAP_COUNT-1:0][SAMPLE_W-1:0] mods;
        logic signed [SAMPLE_W-1:0]         sample;
    } chorus_item_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // sample_in, mod_tap0, mod_tap1, mod_tap2, mod_tap3
    logic [79:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // sample_out
    logic [15:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DELAY_SPAN;
    logic [SPAN_W-1:0]    cfg_data  = '0;

    multitap_modulated_delay_line_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the block state
    logic signed [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
    int unsigned                wr_pos_copy = 0;
    int unsigned                span_copy   = 0;
    bit                         saw_copy    = 1'b0;

    chorus_item_t               pending_items [$];
    logic signed [SAMPLE_W-1:0] expected_mix [$];

    int n_errors   = 0;
    int n_results  = 0;
    int holds_done = 0;
    bit no_idle    = 1'b0;
    bit quiet      = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int k = 0; k < RING_DEPTH; k++) ring_copy[k] = '0;
    end

    function automatic int cos_weight(input int mod);
        int a;
        int i;
        int f;
        a = (mod < 0) ? -mod : mod;
        i = (a >> 11) & 31;
        if (i > 16) i = 16;
        f = a & 2047;
        return (COS_PTS[i] * (2048 - f) + COS_PTS[i + 1] * f) >> 11;
    endfunction

    // expected output for one input, then store the sample and advance
    function automatic logic signed [SAMPLE_W-1:0] mix_taps(input chorus_item_t it);
        int unsigned span;
        int unsigned len;
        int unsigned wp;
        int unsigned li;
        int unsigned ri;
        int          mod;
        longint      rel;
        longint      frac;
        longint      lft;
        longint      rgt;
        longint      v;
        longint      w;
        longint      acc;
        span = (span_copy > SPAN_MAX) ? SPAN_MAX : span_copy;
        len  = span + 2;
        wp   = (wr_pos_copy >= len) ? 0 : wr_pos_copy;
        acc  = 0;
        for (int t = 0; t < TAP_COUNT; t++) begin
            mod  = $signed(it.mods[t]);
            rel  = (longint'(span) * longint'(32768 - mod)) >> (16 - FRAC_BITS);
            frac = rel & ((64'sd1 << FRAC_BITS) - 1);
            li   = ((rel >> FRAC_BITS) + wp + 1) % len;
            ri   = (li + 1) % len;
            lft  = ring_copy[li];
            rgt  = ring_copy[ri];
            v    = lft * (64'sd1 << FRAC_BITS) + (rgt - lft) * frac;
            w    = saw_copy ? longint'(cos_weight(mod)) : 64'sd32768;
            acc += v * w;
        end
        acc = (acc + (64'sd1 << (FRAC_BITS + 14))) >>> (FRAC_BITS + 15);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        ring_copy[wp] = it.sample;
        wp++;
        if (wp >= len) wp = 0;
        wr_pos_copy = wp;
        return SAMPLE_W'(acc);
    endfunction

    task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                   input logic signed [15:0] want);
        n_errors++;
        $display("ERROR at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
    endtask

    // driver
    always @(posedge aclk) begin : drive
        logic nxt_valid;
        int   gap_left;
        nxt_valid = s_tvalid;
        if (!aresetn) begin
            gap_left = 0;
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_mix.push_back(mix_taps(chorus_item_t'(s_tdata)));
                nxt_valid = 1'b0;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 13);
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0) begin
                    s_tdata   <= pending_items.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // monitor and receiver
    always @(posedge aclk) begin : observe
        int stall_left;
        int hold_left;
        logic signed [15:0] want;
        if (!aresetn) begin
            stall_left = 0;
            hold_left  = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_mix.size() == 0) begin
                    report_mismatch("result with none pending", m_tdata, 16'sd0);
                end else begin
                    want = expected_mix.pop_front();
                    if ($signed(m_tdata) !== want)
                        report_mismatch("sample_out", m_tdata, want);
                end
            end
            if (!quiet && holds_done < 2 && pending_items.size() >= 20 &&
                n_results >= 40 + holds_done * 400) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge aclk) begin : watchdog
        int quiet_cycles;
        if (!aresetn) begin
            quiet_cycles = 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
                $display("multitap_modulated_delay_line_top: mismatch");
                $finish;
            end
        end
    end

    function automatic bit in_flight();
        return pending_items.size() != 0 || expected_mix.size() != 0 || s_tvalid;
    endfunction

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPAN_W-1:0] val);
        do @(posedge aclk); while (in_flight());
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DELAY_SPAN: span_copy = val;
            CFG_SAW_WINDOW: saw_copy  = val[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic push_item(input logic [15:0] smp, input logic [15:0] m0,
                             input logic [15:0] m1, input logic [15:0] m2,
                             input logic [15:0] m3);
        chorus_item_t it;
        it.sample  = smp;
        it.mods[0] = m0;
        it.mods[1] = m1;
        it.mods[2] = m2;
        it.mods[3] = m3;
        pending_items.push_back(it);
    endtask

    function automatic logic [15:0] pick_mod();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 15));
            3:       return 16'h8000 + 16'($urandom_range(0, 2047));
            4:       return 16'h7fff - 16'($urandom_range(0, 2047));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++)
            push_item(pick_sample(), pick_mod(), pick_mod(), pick_mod(), pick_mod());
    endtask

    initial begin : stimulus
        int sent;
        int n;
        int unsigned span;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: zero span, no window
        push_item(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        push_item(16'hffff, 16'hffff, 16'h0001, 16'h4000, 16'hc000);

        // short span with the raised cosine window
        set_reg(CFG_DELAY_SPAN, 12'd8);
        set_reg(CFG_SAW_WINDOW, 12'd1);
        push_item(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'hffff);
        push_item(16'h8000, 16'h4000, 16'hc000, 16'h0800, 16'hf801);
        push_item(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_item(16'h7fff, 16'h7801, 16'h87ff, 16'h7c00, 16'h8400);
        push_item(16'h8000, 16'h8001, 16'h07ff, 16'hf800, 16'h2aaa);
        push_item(16'h5555, 16'h1234, 16'hedcb, 16'h7fff, 16'h8000);

        // span beyond the ring limit clamps
        set_reg(CFG_DELAY_SPAN, 12'hfff);
        set_reg(CFG_SAW_WINDOW, 12'hffe);
        push_item(16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h8000);
        push_item(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h0001);
        set_reg(CFG_DELAY_SPAN, 12'd4094);
        push_item(16'h1111, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        push_item(16'heeee, 16'h0000, 16'hffff, 16'h0001, 16'h8000);

        // write position ends up past a shrunk ring
        set_reg(CFG_DELAY_SPAN, 12'd20);
        push_random(9);
        set_reg(CFG_DELAY_SPAN, 12'd5);
        push_random(2);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       span = 0;
                1:       span = $urandom_range(SPAN_MAX, 4095);
                2:       span = $urandom_range(0, 4095);
                3:       span = $urandom_range(100, 600);
                default: span = $urandom_range(1, 40);
            endcase
            n = (span >= 100) ? $urandom_range(30, 300) : $urandom_range(20, 120);
            set_reg(CFG_DELAY_SPAN, SPAN_W'(span));
            if ($urandom_range(0, 1) == 1)
                set_reg(CFG_SAW_WINDOW, {11'($urandom), 1'($urandom)});
            no_idle = ($urandom_range(0, 4) == 0);
            push_random(n);
            sent += n;
        end

        // closing stretch without idling
        quiet   = 1'b1;
        no_idle = 1'b1;
        set_reg(CFG_DELAY_SPAN, SPAN_W'($urandom_range(1, 40)));
        push_random(80);

        do @(posedge aclk); while (in_flight());
        repeat (SETTLE) @(posedge aclk);
        if (expected_mix.size() != 0)
            report_mismatch("results never arrived", 16'sd0, expected_mix[0]);
        if (n_errors == 0) begin
            $display("multitap_modulated_delay_line_top: match");
        end else begin
            $display("multitap_modulated_delay_line_top: mismatch");
        end
        $finish;
    end

endmodule
